FILE: sv/sckq_pkg.sv
// types, codes and the scan code table of the scan code to ascii key queue
// no dependencies; every other file of the block but sckq_if imports this package
package sckq_pkg;

    typedef enum logic [1:0] {
        OP_KEY       = 2'd0,
        OP_READ_CHAR = 2'd1,
        OP_READ_CODE = 2'd2,
        OP_CLEAR_Q   = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SILENT   = 3'd1,
        ST_UNMAPPED = 3'd2,
        ST_FULL     = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        CMD_STORE,
        CMD_SILENT,
        CMD_UNMAPPED,
        CMD_READ_CHAR,
        CMD_READ_CODE,
        CMD_CLEAR
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] ch;
        logic [7:0] code;
    } t_cmd;

    typedef struct packed {
        logic       hit;
        logic       letter;
        logic       caps;
        logic       tab;
        logic [7:0] plain;
        logic [7:0] shifted;
    } t_key_info;

    localparam logic [7:0] BREAK_BIT   = 8'h80;
    localparam logic [7:0] SHIFT_RIGHT = 8'h36;
    localparam logic [7:0] SHIFT_LEFT  = 8'h2A;
    localparam logic [7:0] NO_CHAR     = 8'hFF;

    function automatic t_key_info mk_key(input logic [7:0] plain, input logic [7:0] shifted);
        t_key_info info;
        info         = '0;
        info.hit     = 1'b1;
        info.plain   = plain;
        info.shifted = shifted;
        return info;
    endfunction

    function automatic t_key_info mk_letter(input logic [7:0] plain);
        t_key_info info;
        info        = mk_key(plain, plain & 8'hDF);
        info.letter = 1'b1;
        return info;
    endfunction

    function automatic t_key_info key_lookup(input logic [7:0] code);
        t_key_info info;
        info = '0;
        case (code)
            8'h1E: info = mk_letter(8'h61);
            8'h30: info = mk_letter(8'h62);
            8'h2E: info = mk_letter(8'h63);
            8'h20: info = mk_letter(8'h64);
            8'h12: info = mk_letter(8'h65);
            8'h21: info = mk_letter(8'h66);
            8'h22: info = mk_letter(8'h67);
            8'h23: info = mk_letter(8'h68);
            8'h17: info = mk_letter(8'h69);
            8'h24: info = mk_letter(8'h6A);
            8'h25: info = mk_letter(8'h6B);
            8'h26: info = mk_letter(8'h6C);
            8'h32: info = mk_letter(8'h6D);
            8'h31: info = mk_letter(8'h6E);
            8'h18: info = mk_letter(8'h6F);
            8'h19: info = mk_letter(8'h70);
            8'h10: info = mk_letter(8'h71);
            8'h13: info = mk_letter(8'h72);
            8'h1F: info = mk_letter(8'h73);
            8'h14: info = mk_letter(8'h74);
            8'h16: info = mk_letter(8'h75);
            8'h2F: info = mk_letter(8'h76);
            8'h11: info = mk_letter(8'h77);
            8'h2D: info = mk_letter(8'h78);
            8'h15: info = mk_letter(8'h79);
            8'h2C: info = mk_letter(8'h7A);
            8'h02: info = mk_key(8'h31, 8'h21);
            8'h03: info = mk_key(8'h32, 8'h40);
            8'h04: info = mk_key(8'h33, 8'h23);
            8'h05: info = mk_key(8'h34, 8'h24);
            8'h06: info = mk_key(8'h35, 8'h25);
            8'h07: info = mk_key(8'h36, 8'h5E);
            8'h08: info = mk_key(8'h37, 8'h26);
            8'h09: info = mk_key(8'h38, 8'h2A);
            8'h0A: info = mk_key(8'h39, 8'h28);
            8'h0B: info = mk_key(8'h30, 8'h29);
            8'h0C: info = mk_key(8'h2D, 8'h5F);
            8'h0D: info = mk_key(8'h3D, 8'h2B);
            8'h1A: info = mk_key(8'h5B, 8'h7B);
            8'h1B: info = mk_key(8'h5D, 8'h7D);
            8'h27: info = mk_key(8'h3B, 8'h3A);
            8'h28: info = mk_key(8'h27, 8'h22);
            8'h29: info = mk_key(8'h60, 8'h7E);
            8'h2B: info = mk_key(8'h5C, 8'h7C);
            8'h33: info = mk_key(8'h2C, 8'h3C);
            8'h34: info = mk_key(8'h2E, 8'h3E);
            8'h35: info = mk_key(8'h2F, 8'h3F);
            8'h39: info = mk_key(8'h20, 8'h20);
            8'h1C: info = mk_key(8'h0A, 8'h0A);
            8'h0E: info = mk_key(8'h08, 8'h08);
            8'h3A: begin
                info      = mk_key(8'h63, 8'h63);
                info.caps = 1'b1;
            end
            8'h0F: begin
                info     = mk_key(8'h09, 8'h09);
                info.tab = 1'b1;
            end
            // arrow keys queue as no-character
            8'h48, 8'h4B, 8'h4D, 8'h50: info = mk_key(NO_CHAR, NO_CHAR);
            default: info = '0;
        endcase
        return info;
    endfunction

endpackage

FILE: sv/sckq_if.sv
// valid/ready channel interfaces for the key queue input and result beats
// no dependencies
interface sckq_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] opcode;
    logic [7:0] scan_code;

    modport source (output valid, output opcode, output scan_code, input ready);
    modport sink   (input valid, input opcode, input scan_code, output ready);
endinterface

interface sckq_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic [7:0] data_out;
    logic [8:0] entries_held;

    modport source (output valid, output status, output data_out, output entries_held,
                    input ready);
    modport sink   (input valid, input status, input data_out, input entries_held,
                    output ready);
endinterface

FILE: sv/scan_code_to_ascii_key_fifo_core.sv
// top level of the scan code to ascii key queue: front end, command queue, back end
// depends on sckq_pkg, sckq_if, sckq_front, sckq_cmd_queue and sckq_back
//
//   channel  dir  handshake          payload
//   i_in     in   valid/ready        opcode[1:0], scan_code[7:0]
//   o_out    out  valid/ready        status[2:0], data_out[7:0], entries_held[8:0]
//
// one beat in and one result beat out per cycle sustained while o_out is ready; a
// result shows after its input beat passes the command queue register, then the
// result register that also holds the registered key memory read
// synchronous reset empties the key queue and clears shift and caps; the memory is
// not cleared, entries are only read after they were written
// a stalled o_out holds the result register, the two-entry command queue then fills
// and i_in.ready drops
module scan_code_to_ascii_key_fifo_core #(
    parameter int QUEUE_DEPTH = 512
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sckq_in_if.sink    i_in,
    sckq_out_if.source o_out
);
    import sckq_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    t_cmd push_cmd, pop_cmd;

    sckq_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_cmd   (push_cmd)
    );

    sckq_cmd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_cmd   (push_cmd),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_cmd    (pop_cmd)
    );

    sckq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_cmd   (pop_cmd),
        .o_out       (o_out)
    );

endmodule

FILE: sv/sckq_front.sv
// front end: accepts input beats, tracks shift and caps, translates scan codes
// depends on sckq_pkg and sckq_in_if
module sckq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sckq_in_if.sink       i_in,
    output logic          o_push_valid,
    input  logic          i_push_ready,
    output sckq_pkg::t_cmd o_push_cmd
);
    import sckq_pkg::*;

    logic      r_shift, r_caps;
    logic      n_shift, n_caps;
    logic      accept;
    t_key_info info;
    t_cmd      cmd;
    logic      upper;
    logic [7:0] ch;

    assign i_in.ready   = i_push_ready;
    assign accept       = i_in.valid && i_push_ready;
    assign o_push_valid = i_in.valid;
    assign o_push_cmd   = cmd;

    assign info  = key_lookup(i_in.scan_code);
    assign upper = r_shift ^ (r_caps & info.letter);
    assign ch    = upper ? info.shifted : info.plain;

    always_comb begin
        n_shift   = r_shift;
        n_caps    = r_caps;
        cmd.kind  = CMD_SILENT;
        cmd.ch    = 8'h00;
        cmd.code  = i_in.scan_code;
        case (t_opcode'(i_in.opcode))
            OP_KEY: begin
                if (i_in.scan_code > BREAK_BIT) begin
                    if (i_in.scan_code == (SHIFT_RIGHT | BREAK_BIT)
                        || i_in.scan_code == (SHIFT_LEFT | BREAK_BIT)) begin
                        n_shift = !r_shift;
                    end
                end else if (i_in.scan_code == SHIFT_RIGHT
                             || i_in.scan_code == SHIFT_LEFT) begin
                    n_shift = !r_shift;
                end else if (!info.hit) begin
                    cmd.kind = CMD_UNMAPPED;
                end else if (info.caps) begin
                    n_caps = !r_caps;
                end else if (!(info.tab && r_shift)) begin
                    cmd.kind = CMD_STORE;
                    cmd.ch   = ch;
                end
            end
            OP_READ_CHAR: cmd.kind = CMD_READ_CHAR;
            OP_READ_CODE: cmd.kind = CMD_READ_CODE;
            OP_CLEAR_Q:   cmd.kind = CMD_CLEAR;
            default:      cmd.kind = CMD_CLEAR;
        endcase
    end

    // shift and caps survive a queue clear, only the block reset drops them
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= 1'b0;
            r_caps  <= 1'b0;
        end else if (accept) begin
            r_shift <= n_shift;
            r_caps  <= n_caps;
        end
    end

endmodule

FILE: sv/sckq_cmd_queue.sv
// two-entry command queue between the front end and the key queue back end
// depends on sckq_pkg
module sckq_cmd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  sckq_pkg::t_cmd i_push_cmd,
    output logic           o_pop_valid,
    input  logic           i_pop_ready,
    output sckq_pkg::t_cmd o_pop_cmd
);
    import sckq_pkg::*;

    t_cmd       r_slot [2];
    logic       r_wsel, r_rsel;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_pop_valid  = (r_cnt != 2'd0);
    assign o_pop_cmd    = r_slot[r_rsel];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wsel <= 1'b0;
            r_rsel <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (push) begin
                r_wsel <= !r_wsel;
            end
            if (pop) begin
                r_rsel <= !r_rsel;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wsel] <= i_push_cmd;
        end
    end

endmodule

FILE: sv/sckq_back.sv
// back end: key queue memory, pointers and count, and the result register
// depends on sckq_pkg and sckq_out_if
module sckq_back #(
    parameter int QUEUE_DEPTH = 512
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pop_valid,
    output logic           o_pop_ready,
    input  sckq_pkg::t_cmd i_pop_cmd,
    sckq_out_if.source     o_out
);
    import sckq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    typedef enum logic [1:0] {
        RSEL_REG,
        RSEL_CHAR,
        RSEL_CODE
    } t_rsel;

    logic [15:0]   mem [QUEUE_DEPTH];
    logic [15:0]   r_rd_word;
    logic [AW-1:0] r_wp, r_rp, r_count;
    logic [AW-1:0] n_wp, n_rp, n_count;
    logic          r_ov;
    t_status       r_status, n_status;
    logic [7:0]    r_data, n_data;
    t_rsel         r_sel, n_sel;
    logic [8:0]    r_entries;
    logic          fire, wr_en, rd_en;

    assign o_pop_ready = !r_ov || o_out.ready;
    assign fire        = i_pop_valid && o_pop_ready;

    always_comb begin
        n_wp     = r_wp;
        n_rp     = r_rp;
        n_count  = r_count;
        n_status = ST_OK;
        n_data   = 8'h00;
        n_sel    = RSEL_REG;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        case (i_pop_cmd.kind)
            CMD_STORE: begin
                n_data = i_pop_cmd.ch;
                if (r_count == LAST) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en   = 1'b1;
                    n_wp    = (r_wp == LAST) ? '0 : r_wp + 1'b1;
                    n_count = r_count + 1'b1;
                end
            end
            CMD_SILENT:   n_status = ST_SILENT;
            CMD_UNMAPPED: n_status = ST_UNMAPPED;
            CMD_READ_CHAR, CMD_READ_CODE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                    n_data   = NO_CHAR;
                end else begin
                    rd_en   = 1'b1;
                    n_sel   = (i_pop_cmd.kind == CMD_READ_CHAR) ? RSEL_CHAR : RSEL_CODE;
                    n_rp    = (r_rp == LAST) ? '0 : r_rp + 1'b1;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_wp    = '0;
                n_rp    = '0;
                n_count = '0;
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
            r_ov    <= 1'b0;
        end else begin
            if (fire) begin
                r_wp    <= n_wp;
                r_rp    <= n_rp;
                r_count <= n_count;
                r_ov    <= 1'b1;
            end else if (o_out.ready) begin
                r_ov    <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_status  <= n_status;
            r_data    <= n_data;
            r_sel     <= n_sel;
            r_entries <= 9'(n_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && wr_en) begin
            mem[r_wp] <= {i_pop_cmd.ch, i_pop_cmd.code};
        end
    end

    // read word stays put while the result beat is stalled
    always_ff @(posedge i_clk) begin
        if (fire && rd_en) begin
            r_rd_word <= mem[r_rp];
        end
    end

    assign o_out.valid        = r_ov;
    assign o_out.status       = r_status;
    assign o_out.entries_held = r_entries;

    always_comb begin
        case (r_sel)
            RSEL_CHAR: o_out.data_out = r_rd_word[15:8];
            RSEL_CODE: o_out.data_out = r_rd_word[7:0];
            default:   o_out.data_out = r_data;
        endcase
    end

endmodule

FILE: sv/sckq_checker.sv
// port-level checks on the result channel of the key queue, bound to the top level
// depends on sckq_pkg and scan_code_to_ascii_key_fifo_core
module sckq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [2:0] i_status,
    input logic [7:0] i_data_out,
    input logic [8:0] i_entries_held
);
    import sckq_pkg::*;

    // a stalled result beat keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_status)
            && $stable(i_data_out) && $stable(i_entries_held))
        else $error("result beat changed while stalled");

    a_empty_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status == ST_EMPTY |-> i_data_out == NO_CHAR && i_entries_held == 9'd0)
        else $error("empty read with wrong data or count");

    a_silent_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_SILENT || i_status == ST_UNMAPPED) |-> i_data_out == 8'h00)
        else $error("silent or unmapped key with nonzero data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

endmodule

bind scan_code_to_ascii_key_fifo_core sckq_checker u_sckq_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_status       (o_out.status),
    .i_data_out     (o_out.data_out),
    .i_entries_held (o_out.entries_held)
);

FILE: tb/sv/scan_code_to_ascii_key_fifo_core_test.sv
// self-checking bench for the scan code to ascii key queue: directed rows, then random
// typing, fill to full, drain, more typing; fixed rows check typed results, the rest a
// cycle-free predictor; depends on sckq_pkg, sckq_if and scan_code_to_ascii_key_fifo_core
module scan_code_to_ascii_key_fifo_core_test;
    import sckq_pkg::*;

    localparam int QUEUE_DEPTH   = 512;
    localparam int KEY_COUNT     = 56;
    localparam int LETTER_COUNT  = 26;
    localparam int CAPS_IDX      = 50;
    localparam int ARROW_FIRST   = 52;
    localparam int TYPABLE_LAST  = 49;
    localparam logic [7:0] TAB_CHAR  = 8'h09;
    localparam logic [7:0] CAPS_CODE = 8'h3A;
    localparam int FILL_BEATS    = QUEUE_DEPTH + 4;
    localparam int RANDOM_BEATS  = 150;
    localparam int DIRECTED_ROWS = 25;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        t_status    status;
        logic [7:0] data;
        logic [8:0] held;
    } t_key_result;

    typedef struct packed {
        t_opcode     op;
        logic [7:0]  code;
        logic        fixed;
        t_key_result want;
    } t_stim_row;

    // scan code, plain and shifted character per table slot
    localparam logic [7:0] KEY_CODE [KEY_COUNT] = '{
        8'h1E, 8'h30, 8'h2E, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24,
        8'h25, 8'h26, 8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1F, 8'h14,
        8'h16, 8'h2F, 8'h11, 8'h2D, 8'h15, 8'h2C,
        8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B,
        8'h0C, 8'h0D, 8'h1A, 8'h1B, 8'h27, 8'h28, 8'h29, 8'h2B, 8'h33, 8'h34,
        8'h35,
        8'h39, 8'h1C, 8'h0E, 8'h3A, 8'h0F, 8'h48, 8'h4B, 8'h4D, 8'h50
    };
    localparam logic [7:0] KEY_PLAIN [KEY_COUNT] = '{
        8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A,
        8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74,
        8'h75, 8'h76, 8'h77, 8'h78, 8'h79, 8'h7A,
        8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
        8'h2D, 8'h3D, 8'h5B, 8'h5D, 8'h3B, 8'h27, 8'h60, 8'h5C, 8'h2C, 8'h2E,
        8'h2F,
        8'h20, 8'h0A, 8'h08, 8'h63, 8'h09, 8'h75, 8'h6C, 8'h72, 8'h64
    };
    localparam logic [7:0] KEY_SHIFTED [KEY_COUNT] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
        8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
        8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
        8'h5F, 8'h2B, 8'h7B, 8'h7D, 8'h3A, 8'h22, 8'h7E, 8'h7C, 8'h3C, 8'h3E,
        8'h3F,
        8'h20, 8'h0A, 8'h08, 8'h63, 8'h09, 8'h75, 8'h6C, 8'h72, 8'h64
    };

    // rows with fixed set use the typed result, the rest go through the predictor
    localparam t_stim_row DIRECTED [DIRECTED_ROWS] = '{
        '{OP_READ_CHAR, 8'h00, 1'b1, '{ST_EMPTY,    NO_CHAR, 9'd0}},
        '{OP_READ_CODE, 8'h00, 1'b1, '{ST_EMPTY,    NO_CHAR, 9'd0}},
        '{OP_KEY,       8'h80, 1'b1, '{ST_UNMAPPED, 8'h00,   9'd0}},
        '{OP_KEY,       8'h00, 1'b1, '{ST_UNMAPPED, 8'h00,   9'd0}},
        '{OP_KEY,       8'hFF, 1'b1, '{ST_SILENT,   8'h00,   9'd0}},
        '{OP_KEY,       8'h1E, 1'b1, '{ST_OK,       8'h61,   9'd1}},
        '{OP_KEY,       8'h2A, 1'b1, '{ST_SILENT,   8'h00,   9'd1}},
        '{OP_KEY,       8'h1E, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h0F, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'hAA, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h36, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'hB6, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h3A, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h2C, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h02, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'hBA, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h3A, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h48, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h50, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_KEY,       8'h0F, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_READ_CHAR, 8'h00, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_READ_CODE, 8'h00, 1'b0, '{ST_OK,       8'h00,   9'd0}},
        '{OP_CLEAR_Q,   8'h00, 1'b1, '{ST_OK,       8'h00,   9'd0}},
        '{OP_READ_CHAR, 8'h00, 1'b1, '{ST_EMPTY,    NO_CHAR, 9'd0}},
        '{OP_KEY,       8'h7F, 1'b1, '{ST_UNMAPPED, 8'h00,   9'd0}}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    sckq_in_if  in_if ();
    sckq_out_if out_if ();

    scan_code_to_ascii_key_fifo_core #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predicted keyboard and queue state
    logic       shift_on;
    logic       caps_on;
    logic [7:0] char_mem [QUEUE_DEPTH];
    logic [7:0] code_mem [QUEUE_DEPTH];
    int         wr_idx;
    int         rd_idx;
    int         held_cnt;

    t_key_result key_results_due [$];
    int          mismatch_count;
    int          burst_left;
    int          burst_max;

    function automatic t_key_result predict_key_result(t_opcode op, logic [7:0] code);
        t_key_result r;
        int          idx;
        logic        upper;
        logic [7:0]  ch;
        r.status = ST_OK;
        r.data   = 8'h00;
        case (op)
            OP_KEY: begin
                idx = -1;
                for (int i = 0; i < KEY_COUNT; i++)
                    if (idx < 0 && KEY_CODE[i] == code) idx = i;
                if (code > BREAK_BIT) begin
                    // only the two shift break codes act, every other break is dropped
                    if (code == (SHIFT_RIGHT | BREAK_BIT) || code == (SHIFT_LEFT | BREAK_BIT))
                        shift_on = !shift_on;
                    r.status = ST_SILENT;
                end else if (code == SHIFT_RIGHT || code == SHIFT_LEFT) begin
                    shift_on = !shift_on;
                    r.status = ST_SILENT;
                end else if (idx < 0) begin
                    r.status = ST_UNMAPPED;
                end else if (idx == CAPS_IDX) begin
                    caps_on  = !caps_on;
                    r.status = ST_SILENT;
                end else begin
                    // caps flips letters only
                    upper = shift_on ^ (caps_on && idx < LETTER_COUNT);
                    ch    = upper ? KEY_SHIFTED[idx] : KEY_PLAIN[idx];
                    if (ch == TAB_CHAR && shift_on) begin
                        r.status = ST_SILENT;
                    end else begin
                        if (idx >= ARROW_FIRST) ch = NO_CHAR;
                        r.data = ch;
                        if (held_cnt >= QUEUE_DEPTH - 1) begin
                            r.status = ST_FULL;
                        end else begin
                            char_mem[wr_idx] = ch;
                            code_mem[wr_idx] = code;
                            wr_idx           = (wr_idx + 1) % QUEUE_DEPTH;
                            held_cnt++;
                        end
                    end
                end
            end
            OP_READ_CHAR, OP_READ_CODE: begin
                if (held_cnt == 0) begin
                    r.status = ST_EMPTY;
                    r.data   = NO_CHAR;
                end else begin
                    r.data   = (op == OP_READ_CODE) ? code_mem[rd_idx] : char_mem[rd_idx];
                    rd_idx   = (rd_idx + 1) % QUEUE_DEPTH;
                    held_cnt--;
                end
            end
            default: begin
                // queue clear keeps shift and caps
                wr_idx   = 0;
                rd_idx   = 0;
                held_cnt = 0;
            end
        endcase
        r.held = held_cnt[8:0];
        return r;
    endfunction

    // one input beat, with a random gap whenever the current burst runs out
    task automatic send_beat(t_opcode op, logic [7:0] code, logic fixed = 1'b0,
                             t_key_result want = '0);
        t_key_result r;
        if (burst_left == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, burst_max);
        end
        burst_left--;
        in_if.valid     <= 1'b1;
        in_if.opcode    <= op;
        in_if.scan_code <= code;
        do @(posedge i_clk); while (!in_if.ready);
        r = predict_key_result(op, code);
        key_results_due.push_back(fixed ? want : r);
    endtask

    task automatic wait_for_results();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (key_results_due.size() != 0);
    endtask

    // mostly typing on the table with shift and caps traffic, reads, clears and noise
    task automatic send_random_items(int count);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_beat(OP_KEY, KEY_CODE[$urandom_range(0, KEY_COUNT - 1)]);
            else if (pick < 52)
                send_beat(OP_KEY, ($urandom_range(0, 1) ? SHIFT_LEFT : SHIFT_RIGHT)
                                  | ($urandom_range(0, 1) ? BREAK_BIT : 8'h00));
            else if (pick < 55)
                send_beat(OP_KEY, CAPS_CODE);
            else if (pick < 65)
                send_beat(OP_KEY, 8'($urandom_range(0, 255)));
            else if (pick < 68)
                send_beat(OP_KEY, KEY_CODE[$urandom_range(0, KEY_COUNT - 1)] | BREAK_BIT);
            else if (pick < 80)
                send_beat(OP_READ_CHAR, 8'($urandom_range(0, 255)));
            else if (pick < 92)
                send_beat(OP_READ_CODE, 8'($urandom_range(0, 255)));
            else if (pick < 95)
                send_beat(OP_CLEAR_Q, 8'($urandom_range(0, 255)));
            else
                send_beat(t_opcode'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
        end
    endtask

    // result side stalls on its own pattern: always ready, coin flip, or mostly stalled
    initial begin
        int mode;
        out_if.ready <= 1'b0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(8, 64)) begin
                @(posedge i_clk);
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    default: out_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        t_key_result exp_r;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (key_results_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result beat: status %0d data %02h held %0d",
                             out_if.status, out_if.data_out, out_if.entries_held);
            end else begin
                exp_r = key_results_due.pop_front();
                if (out_if.status !== exp_r.status || out_if.data_out !== exp_r.data
                        || out_if.entries_held !== exp_r.held) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("result mismatch: want status %0d data %02h held %0d, %s%0d %s%02h %s%0d",
                                 exp_r.status, exp_r.data, exp_r.held,
                                 "got status ", out_if.status, "data ", out_if.data_out,
                                 "held ", out_if.entries_held);
                end
            end
        end
    end

    initial begin
        #2000000;
        $display("scan_code_to_ascii_key_fifo_core_test: FAIL");
        $finish;
    end

    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.opcode    <= OP_KEY;
        in_if.scan_code <= 8'h00;
        shift_on        = 1'b0;
        caps_on         = 1'b0;
        wr_idx          = 0;
        rd_idx          = 0;
        held_cnt        = 0;
        mismatch_count  = 0;
        burst_left      = 0;
        burst_max       = 24;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i])
            send_beat(DIRECTED[i].op, DIRECTED[i].code, DIRECTED[i].fixed, DIRECTED[i].want);
        send_random_items(RANDOM_BEATS);

        // fill past full with typable keys, let the queue settle, then drain past empty
        burst_max = 64;
        send_beat(OP_CLEAR_Q, 8'h00);
        repeat (FILL_BEATS) send_beat(OP_KEY, KEY_CODE[$urandom_range(0, TYPABLE_LAST)]);
        wait_for_results();
        repeat (FILL_BEATS)
            send_beat($urandom_range(0, 1) ? OP_READ_CHAR : OP_READ_CODE,
                      8'($urandom_range(0, 255)));
        burst_max = 24;
        send_random_items(RANDOM_BEATS);

        wait_for_results();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && key_results_due.size() == 0)
            $display("scan_code_to_ascii_key_fifo_core_test: PASS");
        else
            $display("scan_code_to_ascii_key_fifo_core_test: FAIL");
        $finish;
    end

endmodule
